>>> sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the source text tokenizer: lexer modes,
// result codes, token kinds, character codes and the queue record.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int OUT_OFFSET_BITS = 32;
    localparam int NUM_SLOTS       = 4;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_IDENT   = 4'd1,
        MODE_INT     = 4'd2,
        MODE_FRAC    = 4'd3,
        MODE_PLUS    = 4'd4,
        MODE_MINUS   = 4'd5,
        MODE_SLASH   = 4'd6,
        MODE_COMMENT = 4'd7,
        MODE_ERRORED = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        ST_TOKEN = 2'd0,
        ST_ERROR = 2'd1,
        ST_END   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        KIND_IDENT     = 5'd0,
        KIND_LET       = 5'd1,
        KIND_FUN       = 5'd2,
        KIND_RETURN    = 5'd3,
        KIND_INT       = 5'd4,
        KIND_FLOAT     = 5'd5,
        KIND_PLUS      = 5'd6,
        KIND_PLUSPLUS  = 5'd7,
        KIND_ADDASSIGN = 5'd8,
        KIND_EQUAL     = 5'd9,
        KIND_COLON     = 5'd10,
        KIND_SEMI      = 5'd11,
        KIND_COMMA     = 5'd12,
        KIND_LPAREN    = 5'd13,
        KIND_RPAREN    = 5'd14,
        KIND_LBRACE    = 5'd15,
        KIND_RBRACE    = 5'd16,
        KIND_ARROW     = 5'd17
    } kind_t;

    // keyword prefix tracker: l le let, f fu fun, r re ret retu retur return
    localparam logic [3:0] KW_NONE   = 4'd0;
    localparam logic [3:0] KW_L      = 4'd1;
    localparam logic [3:0] KW_LE     = 4'd2;
    localparam logic [3:0] KW_LET    = 4'd3;
    localparam logic [3:0] KW_F      = 4'd4;
    localparam logic [3:0] KW_FU     = 4'd5;
    localparam logic [3:0] KW_FUN    = 4'd6;
    localparam logic [3:0] KW_R      = 4'd7;
    localparam logic [3:0] KW_RE     = 4'd8;
    localparam logic [3:0] KW_RET    = 4'd9;
    localparam logic [3:0] KW_RETU   = 4'd10;
    localparam logic [3:0] KW_RETUR  = 4'd11;
    localparam logic [3:0] KW_RETURN = 4'd12;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        status_t                    status;
        kind_t                      kind;
        logic [OUT_OFFSET_BITS-1:0] start_off;
        logic [OUT_OFFSET_BITS-1:0] end_off;
        logic                       neg;
        logic                       last;
    } result_t;

    // slot 0: token closed or error by this byte, 1: single-byte token or
    // error that starts here, 2: flush at end of file, 3: end beat
    typedef struct packed {
        logic    [NUM_SLOTS-1:0] valid;
        result_t [NUM_SLOTS-1:0] slot;
    } rec_t;

endpackage

`default_nettype wire

>>> sv/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per beat in, token, error and end results
// out.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its two-entry record queue has
// room. Each byte yields zero to three result beats; the serializer sends
// one beat per cycle while out_ready is high, so a byte with several results
// holds the output for one beat per result, with the queue absorbing short
// bursts. A result passes from the byte that decides it into the queue, then
// into the output register. Offsets count in OFFSET_BITS and wrap at that
// width; the offset ports carry the low 32 bits, zero-extended for narrower
// settings.
`default_nettype none

module source_text_tokenizer #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  source_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [4:0]       token_kind,
    output logic [31:0]      start_offset,
    output logic [31:0]      end_offset,
    output logic             negative_number,
    output logic             last_result
);
    import stt_pkg::*;

    logic    accept;
    logic    push, pop, full, head_valid;
    rec_t    push_rec, head_rec;
    result_t out_res;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    stt_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .source_byte (source_byte),
        .final_byte  (final_byte),
        .push        (push),
        .push_rec    (push_rec)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    stt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign status          = out_res.status;
    assign token_kind      = out_res.kind;
    assign start_offset    = out_res.start_off;
    assign end_offset      = out_res.end_off;
    assign negative_number = out_res.neg;
    assign last_result     = out_res.last;

endmodule

`default_nettype wire

>>> sv/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Byte classifier and lexer state. Updates mode, offsets and keyword prefix
// per accepted byte and builds one record of up to four result slots.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    source_byte,
    input  wire logic          final_byte,
    output logic               push,
    output stt_pkg::rec_t      push_rec
);
    import stt_pkg::*;

    typedef logic [OFFSET_BITS-1:0] off_t;

    mode_t      mode_reg, mode_next;
    off_t       pos_reg, pos_next;
    off_t       start_reg, start_next;
    logic [3:0] kw_reg, kw_next;
    logic       neg_reg, neg_next;

    mode_t      b_mode;
    logic [3:0] b_kw;
    logic       b_emit;
    result_t    b_res;

    off_t       p, nxt, p1, start_plus1, startn_plus1;
    logic       take_begin;
    rec_t       rec;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
    endfunction

    function automatic logic [3:0] kw_advance(logic [3:0] kp, logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        case (kp)
            KW_L:     r = (c == CH_E) ? KW_LE : KW_NONE;
            KW_LE:    r = (c == CH_T) ? KW_LET : KW_NONE;
            KW_F:     r = (c == CH_U) ? KW_FU : KW_NONE;
            KW_FU:    r = (c == CH_N) ? KW_FUN : KW_NONE;
            KW_R:     r = (c == CH_E) ? KW_RE : KW_NONE;
            KW_RE:    r = (c == CH_T) ? KW_RET : KW_NONE;
            KW_RET:   r = (c == CH_U) ? KW_RETU : KW_NONE;
            KW_RETU:  r = (c == CH_R) ? KW_RETUR : KW_NONE;
            KW_RETUR: r = (c == CH_N) ? KW_RETURN : KW_NONE;
            default:  r = KW_NONE;
        endcase
        return r;
    endfunction

    function automatic kind_t kw_kind(logic [3:0] kp);
        kind_t k;
        case (kp)
            KW_LET:    k = KIND_LET;
            KW_FUN:    k = KIND_FUN;
            KW_RETURN: k = KIND_RETURN;
            default:   k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic result_t mk(status_t st, kind_t k, off_t s, off_t e,
                                   logic n, logic l);
        result_t r;
        r.status    = st;
        r.kind      = k;
        r.start_off = OUT_OFFSET_BITS'(s);
        r.end_off   = OUT_OFFSET_BITS'(e);
        r.neg       = n;
        r.last      = l;
        return r;
    endfunction

    assign p            = pos_reg;
    assign nxt          = pos_reg + off_t'(1);
    assign p1           = nxt;
    assign start_plus1  = start_reg + off_t'(1);
    assign startn_plus1 = start_next + off_t'(1);

    // token start at the current byte
    always_comb
    begin
        b_mode = MODE_IDLE;
        b_kw   = KW_NONE;
        b_emit = 1'b0;
        b_res  = mk(ST_TOKEN, KIND_IDENT, p, p1, 1'b0, 1'b0);
        if (!is_space(source_byte))
        begin
            case (source_byte)
                CH_PLUS:   b_mode = MODE_PLUS;
                CH_MINUS:  b_mode = MODE_MINUS;
                CH_SLASH:  b_mode = MODE_SLASH;
                CH_COMMA:  begin b_emit = 1'b1; b_res.kind = KIND_COMMA;  end
                CH_EQUAL:  begin b_emit = 1'b1; b_res.kind = KIND_EQUAL;  end
                CH_COLON:  begin b_emit = 1'b1; b_res.kind = KIND_COLON;  end
                CH_SEMI:   begin b_emit = 1'b1; b_res.kind = KIND_SEMI;   end
                CH_LPAREN: begin b_emit = 1'b1; b_res.kind = KIND_LPAREN; end
                CH_RPAREN: begin b_emit = 1'b1; b_res.kind = KIND_RPAREN; end
                CH_LBRACE: begin b_emit = 1'b1; b_res.kind = KIND_LBRACE; end
                CH_RBRACE: begin b_emit = 1'b1; b_res.kind = KIND_RBRACE; end
                default:
                begin
                    if (is_alpha(source_byte) || source_byte == CH_UNDER)
                    begin
                        b_mode = MODE_IDENT;
                        if (source_byte == CH_L)
                            b_kw = KW_L;
                        else if (source_byte == CH_F)
                            b_kw = KW_F;
                        else if (source_byte == CH_R)
                            b_kw = KW_R;
                    end
                    else if (is_dig(source_byte))
                    begin
                        b_mode = MODE_INT;
                    end
                    else
                    begin
                        b_mode        = MODE_ERRORED;
                        b_emit        = 1'b1;
                        b_res.status  = ST_ERROR;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        kw_next    = kw_reg;
        neg_next   = neg_reg;
        pos_next   = nxt;
        take_begin = 1'b0;
        rec        = '0;

        case (mode_reg)
            MODE_IDLE:
                take_begin = 1'b1;
            MODE_IDENT:
            begin
                if (is_alpha(source_byte) || is_dig(source_byte) || source_byte == CH_UNDER)
                begin
                    kw_next = kw_advance(kw_reg, source_byte);
                end
                else
                begin
                    rec.valid[0] = 1'b1;
                    rec.slot[0]  = mk(ST_TOKEN, kw_kind(kw_reg), start_reg, p, 1'b0, 1'b0);
                    take_begin   = 1'b1;
                end
            end
            MODE_INT, MODE_FRAC:
            begin
                if (is_dig(source_byte) || source_byte == CH_UNDER)
                begin
                    mode_next = mode_reg;
                end
                else if (source_byte == CH_DOT && mode_reg == MODE_INT)
                begin
                    mode_next = MODE_FRAC;
                end
                else
                begin
                    rec.valid[0] = 1'b1;
                    rec.slot[0]  = mk(ST_TOKEN,
                                      (mode_reg == MODE_INT) ? KIND_INT : KIND_FLOAT,
                                      start_reg, p, neg_reg, 1'b0);
                    take_begin   = 1'b1;
                end
            end
            MODE_PLUS:
            begin
                rec.valid[0] = 1'b1;
                if (source_byte == CH_EQUAL)
                begin
                    rec.slot[0] = mk(ST_TOKEN, KIND_ADDASSIGN, start_reg, nxt, 1'b0, 1'b0);
                    mode_next   = MODE_IDLE;
                end
                else if (source_byte == CH_PLUS)
                begin
                    rec.slot[0] = mk(ST_TOKEN, KIND_PLUSPLUS, start_reg, nxt, 1'b0, 1'b0);
                    mode_next   = MODE_IDLE;
                end
                else
                begin
                    rec.slot[0] = mk(ST_TOKEN, KIND_PLUS, start_reg, p, 1'b0, 1'b0);
                    take_begin  = 1'b1;
                end
            end
            MODE_MINUS:
            begin
                if (source_byte == CH_GT)
                begin
                    rec.valid[0] = 1'b1;
                    rec.slot[0]  = mk(ST_TOKEN, KIND_ARROW, start_reg, nxt, 1'b0, 1'b0);
                    mode_next    = MODE_IDLE;
                end
                else if (is_dig(source_byte))
                begin
                    mode_next = MODE_INT;
                    neg_next  = 1'b1;
                end
                else
                begin
                    rec.valid[0] = 1'b1;
                    rec.slot[0]  = mk(ST_ERROR, KIND_IDENT, start_reg, start_plus1,
                                      1'b0, 1'b0);
                    mode_next    = MODE_ERRORED;
                end
            end
            MODE_SLASH:
            begin
                if (source_byte == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    rec.valid[0] = 1'b1;
                    rec.slot[0]  = mk(ST_ERROR, KIND_IDENT, start_reg, start_plus1,
                                      1'b0, 1'b0);
                    mode_next    = MODE_ERRORED;
                end
            end
            MODE_COMMENT:
            begin
                if (source_byte == CH_LF)
                    mode_next = MODE_IDLE;
            end
            default:
                mode_next = MODE_ERRORED;
        endcase

        if (take_begin)
        begin
            mode_next    = b_mode;
            start_next   = p;
            neg_next     = 1'b0;
            kw_next      = b_kw;
            rec.valid[1] = b_emit;
            rec.slot[1]  = b_res;
        end

        if (final_byte)
        begin
            // flush the pending token, then the end beat
            case (mode_next)
                MODE_IDENT:
                begin
                    rec.valid[2] = 1'b1;
                    rec.slot[2]  = mk(ST_TOKEN, kw_kind(kw_next), start_next, nxt,
                                      1'b0, 1'b0);
                end
                MODE_INT:
                begin
                    rec.valid[2] = 1'b1;
                    rec.slot[2]  = mk(ST_TOKEN, KIND_INT, start_next, nxt, neg_next, 1'b0);
                end
                MODE_FRAC:
                begin
                    rec.valid[2] = 1'b1;
                    rec.slot[2]  = mk(ST_TOKEN, KIND_FLOAT, start_next, nxt, neg_next, 1'b0);
                end
                MODE_PLUS:
                begin
                    rec.valid[2] = 1'b1;
                    rec.slot[2]  = mk(ST_TOKEN, KIND_PLUS, start_next, nxt, 1'b0, 1'b0);
                end
                MODE_MINUS, MODE_SLASH:
                begin
                    rec.valid[2] = 1'b1;
                    rec.slot[2]  = mk(ST_ERROR, KIND_IDENT, start_next, startn_plus1,
                                      1'b0, 1'b0);
                end
                default:
                    rec.valid[2] = 1'b0;
            endcase
            rec.valid[3] = 1'b1;
            rec.slot[3]  = mk(ST_END, KIND_IDENT, nxt, nxt, 1'b0, 1'b1);
            mode_next    = MODE_IDLE;
            pos_next     = '0;
            start_next   = '0;
            kw_next      = KW_NONE;
            neg_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            kw_reg    <= KW_NONE;
            neg_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            kw_reg    <= kw_next;
            neg_reg   <= neg_next;
        end
    end

    assign push     = accept && (rec.valid != '0);
    assign push_rec = rec;

endmodule

`default_nettype wire

>>> sv/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Two-entry record queue between the lexer front and the result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire stt_pkg::rec_t push_rec,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output stt_pkg::rec_t      head_rec
);
    import stt_pkg::*;

    rec_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_rec   = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

>>> sv/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Result serializer. Sends the valid slots of the head record one beat at a
// time, lowest slot first, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire stt_pkg::rec_t head_rec,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output stt_pkg::result_t   out_res
);
    import stt_pkg::*;

    logic [NUM_SLOTS-1:0] sent_reg, sent_next;
    logic [NUM_SLOTS-1:0] pending, pick;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg, out_res_next;
    result_t              pick_res;
    logic                 load;

    assign pending = head_rec.valid & ~sent_reg;
    assign pick    = pending & (~pending + NUM_SLOTS'(1));
    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign pop     = load && ((pending & ~pick) == '0);

    always_comb
    begin
        pick_res = head_rec.slot[0];
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (pick[i])
                pick_res = head_rec.slot[i];
        end
    end

    always_comb
    begin
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = pick_res;
            sent_next      = pop ? '0 : (sent_reg | pick);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

>>> sv/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  source_byte,
    input wire logic        final_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [4:0]  token_kind,
    input wire logic [31:0] start_offset,
    input wire logic [31:0] end_offset,
    input wire logic        negative_number,
    input wire logic        last_result
);
    import stt_pkg::*;

    // hold a stalled source beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(source_byte) && $stable(final_byte))
        else $error("source beat changed while stalled");

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(token_kind)
            && $stable(start_offset) && $stable(end_offset) && $stable(last_result))
        else $error("result beat changed while stalled");

    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last_result || status == ST_END) |->
            last_result && status == ST_END && start_offset == end_offset
            && token_kind == KIND_IDENT && !negative_number)
        else $error("malformed end beat");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ERROR |->
            token_kind == KIND_IDENT && !negative_number && !last_result)
        else $error("malformed error beat");

    a_token_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TOKEN |->
            token_kind <= KIND_ARROW && !last_result
            && (!negative_number || token_kind == KIND_INT || token_kind == KIND_FLOAT))
        else $error("malformed token beat");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire

>>> test/source_text_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// Watches both channels of the tokenizer. Each accepted source byte runs
// through a local lexer that predicts the token, error and end beats the
// byte causes. Each output beat is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  source_byte,
    input  logic        final_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [4:0]  token_kind,
    input  logic [31:0] start_offset,
    input  logic [31:0] end_offset,
    input  logic        negative_number,
    input  logic        last_result,
    input  logic        drain_done,
    output int          mismatch_count,
    output int          pending_results,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    mode_t       lex_mode;
    logic [31:0] byte_pos;
    logic [31:0] tok_start;
    logic [3:0]  kw_state;
    logic        num_neg;
    logic        drained;
    result_t     lexed_results[$];

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || is_numeral(c) || c == CH_UNDER;
    endfunction

    function automatic logic [3:0] next_kw(input logic [3:0] k, input logic [7:0] c);
        case (k)
            KW_L:     return (c == CH_E) ? KW_LE : KW_NONE;
            KW_LE:    return (c == CH_T) ? KW_LET : KW_NONE;
            KW_F:     return (c == CH_U) ? KW_FU : KW_NONE;
            KW_FU:    return (c == CH_N) ? KW_FUN : KW_NONE;
            KW_R:     return (c == CH_E) ? KW_RE : KW_NONE;
            KW_RE:    return (c == CH_T) ? KW_RET : KW_NONE;
            KW_RET:   return (c == CH_U) ? KW_RETU : KW_NONE;
            KW_RETU:  return (c == CH_R) ? KW_RETUR : KW_NONE;
            KW_RETUR: return (c == CH_N) ? KW_RETURN : KW_NONE;
            default:  return KW_NONE;
        endcase
    endfunction

    function automatic kind_t word_kind(input logic [3:0] k);
        case (k)
            KW_LET:    return KIND_LET;
            KW_FUN:    return KIND_FUN;
            KW_RETURN: return KIND_RETURN;
            default:   return KIND_IDENT;
        endcase
    endfunction

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[tokenizer check] %0t: %s", $realtime, what);
    endtask

    task automatic push_result(input status_t st, input kind_t k, input logic [31:0] s,
                               input logic [31:0] e, input logic neg, input logic last);
        result_t r;
        r.status    = st;
        r.kind      = k;
        r.start_off = s;
        r.end_off   = e;
        r.neg       = neg;
        r.last      = last;
        lexed_results.push_back(r);
    endtask

    task automatic flag_error(input logic [31:0] at);
        push_result(ST_ERROR, KIND_IDENT, at, at + 32'd1, 1'b0, 1'b0);
        lex_mode = MODE_ERRORED;
    endtask

    task automatic clear_lexer();
        lex_mode  = MODE_IDLE;
        byte_pos  = '0;
        tok_start = '0;
        kw_state  = KW_NONE;
        num_neg   = 1'b0;
    endtask

    task automatic open_token(input logic [7:0] c, input logic [31:0] p);
        kind_t punct;
        logic  hit;
        punct     = KIND_IDENT;
        hit       = 1'b0;
        lex_mode  = MODE_IDLE;
        tok_start = p;
        num_neg   = 1'b0;
        kw_state  = KW_NONE;
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF: ;
            CH_PLUS:   lex_mode = MODE_PLUS;
            CH_MINUS:  lex_mode = MODE_MINUS;
            CH_SLASH:  lex_mode = MODE_SLASH;
            CH_COMMA:  begin punct = KIND_COMMA;  hit = 1'b1; end
            CH_EQUAL:  begin punct = KIND_EQUAL;  hit = 1'b1; end
            CH_COLON:  begin punct = KIND_COLON;  hit = 1'b1; end
            CH_SEMI:   begin punct = KIND_SEMI;   hit = 1'b1; end
            CH_LPAREN: begin punct = KIND_LPAREN; hit = 1'b1; end
            CH_RPAREN: begin punct = KIND_RPAREN; hit = 1'b1; end
            CH_LBRACE: begin punct = KIND_LBRACE; hit = 1'b1; end
            CH_RBRACE: begin punct = KIND_RBRACE; hit = 1'b1; end
            default:
            begin
                if (is_letter(c) || c == CH_UNDER)
                begin
                    lex_mode = MODE_IDENT;
                    kw_state = (c == CH_L) ? KW_L : (c == CH_F) ? KW_F :
                               (c == CH_R) ? KW_R : KW_NONE;
                end
                else if (is_numeral(c))
                    lex_mode = MODE_INT;
                else
                    flag_error(p);
            end
        endcase
        if (hit)
            push_result(ST_TOKEN, punct, p, p + 32'd1, 1'b0, 1'b0);
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic fin);
        logic [31:0] here;
        logic [31:0] next_pos;
        here     = byte_pos;
        next_pos = byte_pos + 32'd1;
        case (lex_mode)
            MODE_IDLE:
                open_token(c, here);
            MODE_IDENT:
            begin
                if (is_word_char(c))
                    kw_state = next_kw(kw_state, c);
                else
                begin
                    push_result(ST_TOKEN, word_kind(kw_state), tok_start, here, 1'b0, 1'b0);
                    open_token(c, here);
                end
            end
            MODE_INT:
            begin
                if (c == CH_DOT)
                    lex_mode = MODE_FRAC;
                else if (!is_numeral(c) && c != CH_UNDER)
                begin
                    push_result(ST_TOKEN, KIND_INT, tok_start, here, num_neg, 1'b0);
                    open_token(c, here);
                end
            end
            MODE_FRAC:
            begin
                if (!is_numeral(c) && c != CH_UNDER)
                begin
                    push_result(ST_TOKEN, KIND_FLOAT, tok_start, here, num_neg, 1'b0);
                    open_token(c, here);
                end
            end
            MODE_PLUS:
            begin
                if (c == CH_EQUAL)
                begin
                    push_result(ST_TOKEN, KIND_ADDASSIGN, tok_start, next_pos, 1'b0, 1'b0);
                    lex_mode = MODE_IDLE;
                end
                else if (c == CH_PLUS)
                begin
                    push_result(ST_TOKEN, KIND_PLUSPLUS, tok_start, next_pos, 1'b0, 1'b0);
                    lex_mode = MODE_IDLE;
                end
                else
                begin
                    push_result(ST_TOKEN, KIND_PLUS, tok_start, here, 1'b0, 1'b0);
                    open_token(c, here);
                end
            end
            MODE_MINUS:
            begin
                if (c == CH_GT)
                begin
                    push_result(ST_TOKEN, KIND_ARROW, tok_start, next_pos, 1'b0, 1'b0);
                    lex_mode = MODE_IDLE;
                end
                else if (is_numeral(c))
                begin
                    lex_mode = MODE_INT;
                    num_neg  = 1'b1;
                end
                else
                    flag_error(tok_start);
            end
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    lex_mode = MODE_COMMENT;
                else
                    flag_error(tok_start);
            end
            MODE_COMMENT:
            begin
                if (c == CH_LF)
                    lex_mode = MODE_IDLE;
            end
            default:
                lex_mode = MODE_ERRORED;
        endcase

        if (fin)
        begin
            case (lex_mode)
                MODE_IDENT:
                    push_result(ST_TOKEN, word_kind(kw_state), tok_start, next_pos, 1'b0, 1'b0);
                MODE_INT:
                    push_result(ST_TOKEN, KIND_INT, tok_start, next_pos, num_neg, 1'b0);
                MODE_FRAC:
                    push_result(ST_TOKEN, KIND_FLOAT, tok_start, next_pos, num_neg, 1'b0);
                MODE_PLUS:
                    push_result(ST_TOKEN, KIND_PLUS, tok_start, next_pos, 1'b0, 1'b0);
                MODE_MINUS, MODE_SLASH:
                    flag_error(tok_start);
                default: ;
            endcase
            push_result(ST_END, KIND_IDENT, next_pos, next_pos, 1'b0, 1'b1);
            clear_lexer();
        end
        else
            byte_pos = next_pos;
    endtask

    function automatic string field_msg(input string name, input logic [31:0] got,
                                        input logic [31:0] want);
        return $sformatf("result %0d: %s is %0d, predicted %0d", results_checked, name,
                         got, want);
    endfunction

    task automatic check_result();
        result_t want;
        if (lexed_results.size() == 0)
        begin
            report($sformatf("unpredicted beat: status %0d kind %0d start %0d end %0d",
                             status, token_kind, start_offset, end_offset));
            return;
        end
        want = lexed_results.pop_front();
        results_checked++;
        if (status !== want.status)
            report(field_msg("status", 32'(status), 32'(want.status)));
        if (token_kind !== want.kind)
            report(field_msg("token_kind", 32'(token_kind), 32'(want.kind)));
        if (start_offset !== want.start_off)
            report(field_msg("start_offset", start_offset, want.start_off));
        if (end_offset !== want.end_off)
            report(field_msg("end_offset", end_offset, want.end_off));
        if (negative_number !== want.neg)
            report(field_msg("negative_number", 32'(negative_number), 32'(want.neg)));
        if (last_result !== want.last)
            report(field_msg("last_result", 32'(last_result), 32'(want.last)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            lexed_results.delete();
            drained         = 1'b0;
            mismatch_count  = 0;
            results_checked = 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                lex_byte(source_byte, final_byte);
            if (drain_done && !drained)
            begin
                drained = 1'b1;
                if (lexed_results.size() != 0)
                    report($sformatf("%0d predicted results never arrived",
                                     lexed_results.size()));
            end
            pending_results <= lexed_results.size();
        end
    end

endmodule

>>> test/source_text_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Feeds the tokenizer short directed files for keywords, operators and error
// paths, then random files built mostly from well-formed tokens, with random
// idle bursts on both channels. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  source_byte = 8'd0;
    logic        final_byte  = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  status;
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        negative_number;
    logic        last_result;
    logic        drain_done  = 1'b0;
    logic        calm        = 1'b0;
    int          stall_left;
    int          mismatch_count;
    int          pending_results;
    int          results_checked;
    int          bytes_sent  = 0;
    int          files_sent  = 0;
    logic [7:0]  file_bytes[$];

    always #5 clk = ~clk;

    source_text_tokenizer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_byte     (source_byte),
        .final_byte      (final_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .token_kind      (token_kind),
        .start_offset    (start_offset),
        .end_offset      (end_offset),
        .negative_number (negative_number),
        .last_result     (last_result)
    );

    source_text_tokenizer_checker token_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_byte     (source_byte),
        .final_byte      (final_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .token_kind      (token_kind),
        .start_offset    (start_offset),
        .end_offset      (end_offset),
        .negative_number (negative_number),
        .last_result     (last_result),
        .drain_done      (drain_done),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // hold off the result channel in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic [7:0] pick_letter();
        logic [7:0] ofs;
        ofs = 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? CH_LA + ofs : CH_UA + ofs;
    endfunction

    function automatic logic [7:0] pick_digit();
        logic [7:0] ofs;
        ofs = 8'($urandom_range(0, 9));
        return CH_0 + ofs;
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0:       return pick_digit();
            1:       return CH_UNDER;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_CR;
            3:       return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    task automatic add_fragment(output logic broke);
        int         pick;
        logic [7:0] b;
        broke = 1'b0;
        pick  = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 8))
                0:       add_text("let");
                1:       add_text("fun");
                2:       add_text("return");
                3:       add_text("le");
                4:       add_text("fu");
                5:       add_text("retur");
                6:       add_text("lets");
                7:       add_text("fund");
                default: add_text("return_");
            endcase
        end
        else if (pick < 35)
        begin
            file_bytes.push_back($urandom_range(0, 4) == 0 ? CH_UNDER : pick_letter());
            repeat ($urandom_range(0, 5))
                file_bytes.push_back(pick_word_char());
        end
        else if (pick < 55)
        begin
            if ($urandom_range(0, 3) == 0)
                file_bytes.push_back(CH_MINUS);
            file_bytes.push_back(pick_digit());
            repeat ($urandom_range(0, 3))
                file_bytes.push_back($urandom_range(0, 4) == 0 ? CH_UNDER : pick_digit());
            if ($urandom_range(0, 1))
            begin
                file_bytes.push_back(CH_DOT);
                repeat ($urandom_range(0, 3))
                    file_bytes.push_back(pick_digit());
            end
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 11))
                0:       add_text("++");
                1:       add_text("+=");
                2:       add_text("->");
                3:       add_text("+");
                4:       add_text("=");
                5:       add_text(":");
                6:       add_text(";");
                7:       add_text(",");
                8:       add_text("(");
                9:       add_text(")");
                10:      add_text("{");
                default: add_text("}");
            endcase
        end
        else if (pick < 92)
            file_bytes.push_back(pick_blank());
        else if (pick < 97)
        begin
            add_text("//");
            repeat ($urandom_range(0, 6))
            begin
                b = 8'($urandom_range(0, 255));
                file_bytes.push_back(b == CH_LF ? CH_SPACE : b);
            end
            if ($urandom_range(0, 3) != 0)
                file_bytes.push_back(CH_LF);
        end
        else
        begin
            broke = 1'b1;
            case ($urandom_range(0, 2))
                0:
                    file_bytes.push_back(8'($urandom_range(0, 255)));
                1:
                begin
                    file_bytes.push_back(CH_MINUS);
                    file_bytes.push_back(pick_letter());
                end
                default:
                begin
                    file_bytes.push_back(CH_SLASH);
                    file_bytes.push_back(pick_letter());
                end
            endcase
        end
    endtask

    task automatic put_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        source_byte <= b;
        final_byte  <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            put_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
        file_bytes.delete();
    endtask

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int   counted;
        int   n_frag;
        logic broke;
        counted = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_text("let=fun->return");
        send_file();
        add_text("1.2.");
        file_bytes.push_back(8'hff);
        send_file();
        add_text("-a");
        send_file();
        add_text("/");
        send_file();
        file_bytes.push_back(8'h00);
        send_file();
        add_text("+\f//x");
        send_file();

        while (counted < 300)
        begin
            calm  <= (counted >= 240);
            broke = 1'b0;
            n_frag = $urandom_range(1, 10);
            for (int f = 0; f < n_frag && !broke; f++)
            begin
                add_fragment(broke);
                if (!broke && $urandom_range(0, 9) < 4)
                    file_bytes.push_back(pick_blank());
            end
            counted += file_bytes.size();
            if (broke)
                repeat ($urandom_range(0, 2))
                    file_bytes.push_back(8'($urandom_range(0, 255)));
            send_file();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        drain_done <= 1'b1;
        repeat (2)
            @(posedge clk);

        $display("Tokenized %0d source bytes in %0d files with idle bursts on both sides;",
                 bytes_sent, files_sent);
        $display("%0d token, error and end results compared.", results_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
